// ----- rtl/core/slt_pkg.sv -----
// shared types and constants for the stable level threshold tracker
// used by slt_isqrt and stable_level_threshold_tracker; no dependencies

package slt_pkg;

   // default sizes
   localparam int CHANNELS_DEF    = 5;
   localparam int SAMPLE_BITS_DEF = 10;

   // run length counter
   localparam int RUN_BITS = 8;

   // register reset values
   localparam int TOL_RESET     = 2;
   localparam int MIN_RUN_RESET = 5;

   // csr port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      REG_TOLERANCE = 1'b0,
      REG_MIN_RUN   = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_EMIT
   } state_type;

   // status of the square root unit
   typedef struct packed {
      logic busy;
      logic done;
   } root_stat_type;

endpackage

// ----- rtl/core/slt_isqrt.sv -----
// iterative integer square root, one root bit per cycle, rounded to nearest
// depends on slt_pkg

module slt_isqrt #(
   parameter int ROOT_BITS = slt_pkg::SAMPLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [2*ROOT_BITS-1:0]     radicand,
   output logic [ROOT_BITS-1:0]       root,
   output slt_pkg::root_stat_type     stat
);
   import slt_pkg::*;

   localparam int CNT_W = $clog2(ROOT_BITS);

   logic [2*ROOT_BITS-1:0] rad_ff, rad_in;
   logic [ROOT_BITS+1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [ROOT_BITS+1:0]   rem_shift;
   logic [ROOT_BITS+1:0]   trial;
   logic                   take;

   // bring down the next two radicand bits and try root*4+1
   assign rem_shift = {rem_ff[ROOT_BITS-1:0], rad_ff[2*ROOT_BITS-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign take      = (rem_shift >= trial);

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[2*ROOT_BITS-3:0], 2'b00};
         rem_in  = take ? (rem_shift - trial) : rem_shift;
         root_in = {root_ff[ROOT_BITS-2:0], take};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   // remainder above the root means the true root is past the half point
   assign root = root_ff + ROOT_BITS'(rem_ff > {2'b00, root_ff});

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- rtl/core/stable_level_threshold_tracker.sv -----
// stable level threshold tracker, top level: per-channel run tracking,
// stable extremes and a geometric-mean threshold; depends on slt_pkg and slt_isqrt
//
// sequence when the threshold is kept: accept, evaluate, emit into the result register;
//   when it is recomputed: accept, evaluate, multiply, root start, root wait, emit
// flow: one item at a time, the next is accepted only after the emit step, which waits for a free result register
// reset: synchronous, clears all channel state and loads register defaults

module stable_level_threshold_tracker #(
   parameter int CHANNELS    = slt_pkg::CHANNELS_DEF,
   parameter int SAMPLE_BITS = slt_pkg::SAMPLE_BITS_DEF,
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   localparam int REQ_W = ((CH_W + SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((CH_W + 4 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_W-1:0]              req_tdata,  // channel, sample
   // result items
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_W-1:0]              rsp_tdata,  // out_channel, level_now, low_level,
                                                     // high_level, threshold
   output logic                          rsp_tuser,  // threshold_valid
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [slt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [slt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [slt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);
   import slt_pkg::*;

   localparam logic [SAMPLE_BITS-1:0] LEVEL_MAX = '1;
   localparam logic [RUN_BITS-1:0]    RUN_MAX   = '1;
   localparam logic [CH_W:0]          CH_LIMIT  = (CH_W + 1)'(CHANNELS);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [SAMPLE_BITS-1:0] tol_ff;
   logic [RUN_BITS-1:0]    min_run_ff;
   logic                   csr_write;
   reg_index_type          csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // word-aligned registers, low address bits ignored
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff     <= SAMPLE_BITS'(TOL_RESET);
         min_run_ff <= RUN_BITS'(MIN_RUN_RESET);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TOLERANCE: tol_ff     <= csr_pwdata[SAMPLE_BITS-1:0];
            REG_MIN_RUN:   min_run_ff <= csr_pwdata[RUN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_TOLERANCE: csr_prdata = CSR_DATA_W'(tol_ff);
         REG_MIN_RUN:   csr_prdata = CSR_DATA_W'(min_run_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // item capture and per-channel state
   // ---------------------------------------------------------------
   state_type state_ff, state_in;

   logic [CH_W-1:0]        ch_ff;
   logic [SAMPLE_BITS-1:0] smp_ff;
   logic                   req_take;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (req_take) begin
         ch_ff  <= req_tdata[CH_W-1:0];
         smp_ff <= req_tdata[CH_W +: SAMPLE_BITS];
      end
   end

   logic                   primed_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] start_ff  [CHANNELS];
   logic [RUN_BITS-1:0]    len_ff    [CHANNELS];
   logic [SAMPLE_BITS-1:0] min_ff    [CHANNELS];
   logic [SAMPLE_BITS-1:0] max_ff    [CHANNELS];
   logic [SAMPLE_BITS-1:0] border_ff [CHANNELS];

   logic                   in_range;
   logic [SAMPLE_BITS-1:0] cur_start, cur_min, cur_max;
   logic [SAMPLE_BITS-1:0] diff;
   logic                   stable_run;
   logic                   changed;

   logic [SAMPLE_BITS-1:0] start_in, min_in, max_in;
   logic [RUN_BITS-1:0]    len_in;
   logic                   need_root_in;

   // channels past the configured count leave all state alone
   assign in_range  = ({1'b0, ch_ff} < CH_LIMIT);
   assign cur_start = start_ff[ch_ff];
   assign cur_min   = min_ff[ch_ff];
   assign cur_max   = max_ff[ch_ff];

   // run update from the captured sample
   always_comb begin
      diff         = (cur_start > smp_ff) ? (cur_start - smp_ff) : (smp_ff - cur_start);
      stable_run   = (len_ff[ch_ff] >= min_run_ff);
      start_in     = cur_start;
      len_in       = len_ff[ch_ff];
      min_in       = cur_min;
      max_in       = cur_max;
      changed      = 1'b0;
      if (!primed_ff[ch_ff]) begin
         // first sample opens the first run
         start_in = smp_ff;
         len_in   = RUN_BITS'(1);
      end else if (diff <= tol_ff) begin
         if (len_ff[ch_ff] != RUN_MAX) begin
            len_in = len_ff[ch_ff] + RUN_BITS'(1);
         end
      end else begin
         // run broken: a long enough run may move the extremes
         if (stable_run && (cur_start > cur_max)) begin
            max_in  = cur_start;
            changed = 1'b1;
         end
         if (stable_run && (cur_start < cur_min)) begin
            min_in  = cur_start;
            changed = 1'b1;
         end
         start_in = smp_ff;
         len_in   = RUN_BITS'(1);
      end
      need_root_in = changed && (min_in != LEVEL_MAX) && (max_in != '0);
   end

   // ---------------------------------------------------------------
   // square root of min * max
   // ---------------------------------------------------------------
   logic [2*SAMPLE_BITS-1:0] prod_ff;
   logic [SAMPLE_BITS-1:0]   root;
   logic                     root_start;
   root_stat_type            root_stat;

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= (2*SAMPLE_BITS)'(cur_min) * (2*SAMPLE_BITS)'(cur_max);
      end
   end

   slt_isqrt #(
      .ROOT_BITS (SAMPLE_BITS)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (prod_ff),
      .root     (root),
      .stat     (root_stat)
   );

   // channel state writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            primed_ff[i] <= 1'b0;
            start_ff[i]  <= '0;
            len_ff[i]    <= '0;
            min_ff[i]    <= LEVEL_MAX;
            max_ff[i]    <= '0;
            border_ff[i] <= '0;
         end
      end else begin
         if ((state_ff == ST_EVAL) && in_range) begin
            primed_ff[ch_ff] <= 1'b1;
            start_ff[ch_ff]  <= start_in;
            len_ff[ch_ff]    <= len_in;
            min_ff[ch_ff]    <= min_in;
            max_ff[ch_ff]    <= max_in;
         end
         if ((state_ff == ST_ROOT_WAIT) && root_stat.done) begin
            border_ff[ch_ff] <= root;
         end
      end
   end

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   logic rsp_load;
   logic rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      root_start = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (in_range && need_root_in) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_MUL: begin
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            root_start = 1'b1;
            state_in   = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (root_stat.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait for the output register to free up
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------
   logic [CH_W-1:0]        out_ch_ff;
   logic [SAMPLE_BITS-1:0] out_level_ff, out_low_ff, out_high_ff, out_thr_ff;
   logic                   out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_ch_ff    <= ch_ff;
         out_level_ff <= smp_ff;
         if (in_range) begin
            out_low_ff   <= cur_min;
            out_high_ff  <= cur_max;
            out_thr_ff   <= border_ff[ch_ff];
            out_valid_ff <= (cur_min != LEVEL_MAX) && (cur_max != '0);
         end else begin
            // unknown channel reports empty extremes
            out_low_ff   <= LEVEL_MAX;
            out_high_ff  <= '0;
            out_thr_ff   <= '0;
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_W'({out_thr_ff, out_high_ff, out_low_ff, out_level_ff, out_ch_ff});
   assign rsp_tuser  = out_valid_ff;

`ifndef NO_ASSERTIONS
   // a valid threshold always sits between the stable extremes
   a_thr_between: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && out_valid_ff) |->
         (out_low_ff <= out_thr_ff) && (out_thr_ff <= out_high_ff))
      else $error("threshold outside stable extremes");

   // the root unit only finishes while the sequencer waits for it
   a_root_done: assert property (@(posedge clock) disable iff (reset)
      root_stat.done |-> (state_ff == ST_ROOT_WAIT))
      else $error("square root done outside wait state");

   // the root unit is quiet whenever a new item can come in
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !root_stat.busy)
      else $error("square root busy while idle");

   // a new result only appears out of the emit step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit state");
`endif

endmodule

// ----- tb/sv/tb_stable_level_threshold_tracker.sv -----
// self-checking testbench for stable_level_threshold_tracker: stream in/out, apb registers
// needs slt_pkg and the tracker rtl; keeps its own per-channel tracker model for checking

module tb_stable_level_threshold_tracker;
   import slt_pkg::*;

   localparam int NUM_CH = CHANNELS_DEF;
   localparam logic [9:0] NO_LOW = 10'h3FF;                    // stable minimum before any run
   localparam logic [CSR_ADDR_W-1:0] TOL_ADDR = CSR_ADDR_W'(4 * REG_TOLERANCE);
   localparam logic [CSR_ADDR_W-1:0] MIN_RUN_ADDR = CSR_ADDR_W'(4 * REG_MIN_RUN);
   localparam int LONG_HOLD = 400;                             // receiver back-pressure, cycles
   localparam int REPORT_LIMIT = 10;

   // one result item, fields in rsp order
   typedef struct packed {
      logic [2:0] ch;
      logic [9:0] level;
      logic [9:0] low;
      logic [9:0] high;
      logic [9:0] thr;
      logic       valid;
   } level_report_type;

   // one directed row: the item itself plus a hand-written result where typed is set
   typedef struct packed {
      logic             typed;
      level_report_type want;
   } stim_row_type;

   // defaults after reset: tolerance 2, min_run 5
   localparam int DIRECTED_ROWS = 25;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // first sample on a fresh channel only primes it
      '{1'b1, '{3'd0, 10'd0,    NO_LOW, 10'd0, 10'd0, 1'b0}},
      // run at the bottom of the range, five long
      '{1'b0, '{3'd0, 10'd1,    10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd0, 10'd2,    10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd0, 10'd0,    10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd0, 10'd1,    10'd0, 10'd0, 10'd0, 1'b0}},
      // jump to full scale: minimum found, maximum not yet
      '{1'b0, '{3'd0, 10'd1023, 10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd0, 10'd1023, 10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd0, 10'd1022, 10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd0, 10'd1021, 10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd0, 10'd1023, 10'd0, 10'd0, 10'd0, 1'b0}},
      // break: maximum 1023 with minimum 0 gives a zero threshold
      '{1'b0, '{3'd0, 10'd512,  10'd0, 10'd0, 10'd0, 1'b0}},
      // channels past the last sensor leave state alone and report blanks; then channel 1 is primed
      '{1'b1, '{3'd5, 10'd1023, NO_LOW, 10'd0, 10'd0, 1'b0}},
      '{1'b1, '{3'd6, 10'd0,    NO_LOW, 10'd0, 10'd0, 1'b0}},
      '{1'b1, '{3'd7, 10'd682,  NO_LOW, 10'd0, 10'd0, 1'b0}},
      '{1'b1, '{3'd1, 10'd1023, NO_LOW, 10'd0, 10'd0, 1'b0}},
      // bright run then dark run on channel 1
      '{1'b0, '{3'd1, 10'd1023, 10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd1, 10'd1023, 10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd1, 10'd1023, 10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd1, 10'd1023, 10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd1, 10'd1,    10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd1, 10'd1,    10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd1, 10'd3,    10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd1, 10'd0,    10'd0, 10'd0, 10'd0, 1'b0}},
      '{1'b0, '{3'd1, 10'd2,    10'd0, 10'd0, 10'd0, 1'b0}},
      // break: threshold becomes round(sqrt(1 * 1023))
      '{1'b0, '{3'd1, 10'd700,  10'd0, 10'd0, 10'd0, 1'b0}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;        // channel [2:0], sample [12:3]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;             // out_channel, level_now, low_level, high_level, threshold
   logic        rsp_tuser;             // threshold_valid
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   // hand-written expectation travels with the item it belongs to
   logic             req_typed = 1'b0;
   level_report_type req_fixed = '0;

   // tracker model state, one entry per channel
   logic        primed [NUM_CH];
   logic [9:0]  run_first [NUM_CH];
   logic [7:0]  run_len [NUM_CH];
   logic [9:0]  low_seen [NUM_CH];
   logic [9:0]  high_seen [NUM_CH];
   logic [9:0]  border [NUM_CH];
   logic [9:0]  tol_reg;
   logic [7:0]  min_run_reg;

   level_report_type expected_reports [$];

   int failures = 0;
   int items_taken = 0;
   int reports_seen = 0;
   int settings_applied = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_orders = 0;
   int cfg_tol = TOL_RESET;
   int cfg_min_run = MIN_RUN_RESET;

   stable_level_threshold_tracker DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // exact integer square root, rounded to nearest
   function automatic logic [9:0] rounded_root(input logic [19:0] x);
      logic [10:0] r;
      logic [10:0] trial;
      r = '0;
      for (int b = 9; b >= 0; b--) begin
         trial = r | (11'd1 << b);
         if (22'(trial) * 22'(trial) <= 22'(x))
            r = trial;
      end
      // remainder above r means x is past (r + 0.5)^2
      if (22'(x) - 22'(r) * 22'(r) > 22'(r))
         r = r + 11'd1;
      return r[9:0];
   endfunction

   // advance one channel by one sample and return the report it should produce
   function automatic level_report_type track_sample(input logic [2:0] ch,
                                                     input logic [9:0] smp);
      level_report_type r;
      logic [9:0] first;
      logic [9:0] gap;
      logic       moved;
      r.ch = ch;
      r.level = smp;
      r.low = NO_LOW;
      r.high = '0;
      r.thr = '0;
      r.valid = 1'b0;
      // nonexistent sensor: blank report, nothing touched
      if (int'(ch) >= NUM_CH)
         return r;
      if (!primed[ch]) begin
         primed[ch] = 1'b1;
         run_first[ch] = smp;
         run_len[ch] = 8'd1;
      end else begin
         first = run_first[ch];
         gap = (first > smp) ? first - smp : smp - first;
         if (gap <= tol_reg) begin
            // run goes on, counter sticks at full scale
            if (run_len[ch] != 8'hFF)
               run_len[ch] = run_len[ch] + 8'd1;
         end else begin
            moved = 1'b0;
            // a zero min_run passes every run, same as one
            if (run_len[ch] >= min_run_reg) begin
               if (first > high_seen[ch]) begin
                  high_seen[ch] = first;
                  moved = 1'b1;
               end
               if (first < low_seen[ch]) begin
                  low_seen[ch] = first;
                  moved = 1'b1;
               end
            end
            if (moved && low_seen[ch] != NO_LOW && high_seen[ch] != 10'd0)
               border[ch] = rounded_root(20'(low_seen[ch]) * 20'(high_seen[ch]));
            run_first[ch] = smp;
            run_len[ch] = 8'd1;
         end
      end
      r.low = low_seen[ch];
      r.high = high_seen[ch];
      r.thr = border[ch];
      r.valid = (low_seen[ch] != NO_LOW) && (high_seen[ch] != 10'd0);
      return r;
   endfunction

   // everything observed on the ports at each rising edge
   always @(posedge clock) begin : scoreboard
      level_report_type got;
      level_report_type want;
      if (reset) begin
         tol_reg <= 10'(TOL_RESET);
         min_run_reg <= 8'(MIN_RUN_RESET);
         for (int c = 0; c < NUM_CH; c++) begin
            primed[c] = 1'b0;
            run_first[c] = '0;
            run_len[c] = '0;
            low_seen[c] = NO_LOW;
            high_seen[c] = '0;
            border[c] = '0;
         end
      end else begin
         // register writes land in the model at the same edge as in the block
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == TOL_ADDR)
               tol_reg <= csr_pwdata[9:0];
            else if (csr_paddr == MIN_RUN_ADDR)
               min_run_reg <= csr_pwdata[7:0];
         end
         // result side: compare against the oldest outstanding report
         if (rsp_tvalid && rsp_tready) begin
            got.ch = rsp_tdata[2:0];
            got.level = rsp_tdata[12:3];
            got.low = rsp_tdata[22:13];
            got.high = rsp_tdata[32:23];
            got.thr = rsp_tdata[42:33];
            got.valid = rsp_tuser;
            reports_seen++;
            if (expected_reports.size() == 0) begin
               if (failures < REPORT_LIMIT)
                  $display("%0t: result item with nothing outstanding: ch %0d level %0d",
                           $time, got.ch, got.level);
               failures++;
            end else begin
               want = expected_reports.pop_front();
               if (got !== want) begin
                  if (failures < REPORT_LIMIT)
                     $display({"%0t: mismatch ch/level/low/high/thr/valid expected ",
                               "%0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d"},
                              $time, want.ch, want.level, want.low, want.high, want.thr,
                              want.valid, got.ch, got.level, got.low, got.high, got.thr,
                              got.valid);
                  failures++;
               end
            end
         end
         // input side: model runs on every accepted item
         if (req_tvalid && req_tready) begin
            want = track_sample(req_tdata[2:0], req_tdata[12:3]);
            if (req_typed)
               want = req_fixed;
            expected_reports.push_back(want);
            items_taken++;
         end
      end
   end

   // result side ready: random holds plus one long hold on request
   initial begin : receiver
      int stalls_done;
      stalls_done = 0;
      forever begin
         @(posedge clock);
         if (stall_orders != stalls_done) begin
            stalls_done++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // offer one item, with random gaps first; returns at the accepting edge
   task automatic send_sample(input logic [2:0] ch, input logic [9:0] smp,
                              input logic typed, input level_report_type fixed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, smp, ch};
      req_typed <= typed;
      req_fixed <= fixed;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and wait for every outstanding report
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // apb write followed by a read back of the same register
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] readback;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // read setup
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== value) begin
         if (failures < REPORT_LIMIT)
            $display("%0t: register %0d read back %0d, wrote %0d",
                     $time, idx, readback, value);
         failures++;
      end
   endtask

   task automatic apply_settings(input int tol, input int min_run);
      cfg_tol = tol;
      cfg_min_run = min_run;
      csr_write(REG_TOLERANCE, 32'(tol));
      csr_write(REG_MIN_RUN, 32'(min_run));
      settings_applied++;
   endtask

   // mostly runs of near-equal samples on one channel, some stray items and broken runs
   task automatic random_runs(input int count, input int level_lo, input int level_hi);
      int sent;
      int base;
      int s;
      int spread;
      int length;
      int max_len;
      logic [2:0] ch;
      sent = 0;
      spread = (cfg_tol < 12) ? cfg_tol : 12;
      max_len = (cfg_min_run > 8) ? 11 : cfg_min_run + 3;
      while (sent < count) begin
         if ($urandom_range(99) < 8) begin
            // stray item, any channel code including unused ones
            send_sample(3'($urandom_range(7)), 10'($urandom_range(1023)), 1'b0, '0);
            sent++;
         end else begin
            ch = 3'($urandom_range(NUM_CH - 1));
            base = $urandom_range(level_hi, level_lo);
            length = $urandom_range(max_len, 1);
            if (length > count - sent)
               length = count - sent;
            for (int k = 0; k < length; k++) begin
               s = base + $urandom_range(2 * spread) - spread;
               // now and then a glitch that breaks the run early
               if ($urandom_range(99) < 5)
                  s = $urandom_range(1023);
               if (s < 0)
                  s = 0;
               if (s > 1023)
                  s = 1023;
               send_sample(ch, 10'(s), 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table on reset defaults, slow sender and slower receiver
      send_idle_pct = 24;
      recv_idle_pct = 71;
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_sample(DIRECTED[i].want.ch, DIRECTED[i].want.level, DIRECTED[i].typed,
                     DIRECTED[i].want);
      settle();

      // zero tolerance, every run stable; mid-range levels
      apply_settings(0, 1);
      random_runs(250, 300, 700);
      settle();

      // widest tolerance and longest min_run: one endless run saturates the counter
      apply_settings(1023, 255);
      for (int i = 0; i < 270; i++)
         send_sample(3'd2, 10'($urandom_range(1023)), 1'b0, '0);
      random_runs(20, 0, 1023);
      settle();

      // zero min_run behaves as one; idle ratios swapped
      send_idle_pct = 71;
      recv_idle_pct = 24;
      apply_settings(7, 0);
      random_runs(250, 100, 900);
      settle();

      // no idling, with one long receiver hold so the input backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(3, 4);
      stall_orders++;
      random_runs(300, 0, 1023);
      settle();

      repeat (20) @(posedge clock);
      $display("covered %0d samples and %0d reports over %0d register settings",
               items_taken, reports_seen, settings_applied + 1);
      $display("including saturated runs, unused channel codes and a long output hold");
      if (failures == 0 && expected_reports.size() == 0)
         $display("stable_level_threshold_tracker test passed");
      else
         $display("stable_level_threshold_tracker test failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #1000000;
      $display("stable_level_threshold_tracker test failed");
      $finish;
   end

endmodule
